// ----- hw/rtl/assert_macros.svh -----
// Assertion macros shared by the integer n-th root RTL.
// Depends on nothing; included by the files that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define INR_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("inr assertion failed");

// Next-cycle implication, disabled while reset is high.
`define INR_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("inr assertion failed");

`endif

// ----- hw/rtl/inr_pkg.sv -----
// Package for the integer n-th root block: constants, sequencer states and
// the status struct of the shared multiplier. Depends on nothing.
`default_nettype none

package inr_pkg;

   localparam int VALUE_BITS_DEF = 31;
   localparam int DEGREE_BITS    = 5;
   // width of one multiplier digit taken from the candidate, one digit at a time
   localparam int MUL_DIGIT_BITS = 16;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CAND,
      ST_POWER,
      ST_WAIT,
      ST_CHECK,
      ST_RESULT
   } state_type;

   typedef struct packed {
      logic busy;
      logic done;
   } mul_stat_type;

endpackage

`default_nettype wire

// ----- hw/rtl/inr_req_if.sv -----
// Request channel of the integer n-th root block: valid/ready and payload.
// Depends on inr_pkg for the degree width.
`default_nettype none

interface inr_req_if #(
   parameter int VALUE_BITS = inr_pkg::VALUE_BITS_DEF
);
   logic                          valid;
   logic                          ready;
   logic [VALUE_BITS-1:0]         value;
   logic [inr_pkg::DEGREE_BITS-1:0] degree;

   modport source (output valid, output value, output degree, input ready);
   modport sink   (input valid, input value, input degree, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/inr_rsp_if.sv -----
// Response channel of the integer n-th root block: valid/ready and payload.
// Depends on inr_pkg for the default value width.
`default_nettype none

interface inr_rsp_if #(
   parameter int VALUE_BITS = inr_pkg::VALUE_BITS_DEF
);
   logic                  valid;
   logic                  ready;
   logic [VALUE_BITS-1:0] root;
   logic                  exact;
   logic                  bad_degree;

   modport source (output valid, output root, output exact, output bad_degree, input ready);
   modport sink   (input valid, input root, input exact, input bad_degree, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/inr_mul_unit.sv -----
// Shared multiplier of the n-th root block: multiplies two VALUE_BITS operands
// one digit of the second operand at a time, most significant digit first.
// Depends on inr_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module inr_mul_unit #(
   parameter int VALUE_BITS = inr_pkg::VALUE_BITS_DEF,
   localparam int DIG  = inr_pkg::MUL_DIGIT_BITS,
   localparam int NDIG = (VALUE_BITS + DIG - 1) / DIG,
   localparam int ACCW = VALUE_BITS + NDIG * DIG
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   input  wire logic [VALUE_BITS-1:0] op_a,
   input  wire logic [VALUE_BITS-1:0] op_b,
   output logic      [ACCW-1:0]       product,
   output inr_pkg::mul_stat_type      stat
);

   localparam int PPW  = VALUE_BITS + DIG;
   localparam int BPW  = NDIG * DIG;
   localparam int CI_W = (NDIG > 1) ? $clog2(NDIG) : 1;

   logic            busy_ff, busy_in;
   logic            add_ff, add_in;   // high in the accumulate half of a digit
   logic [CI_W-1:0] ci_ff, ci_in;
   logic [PPW-1:0]  pp_ff, pp_in;
   logic [ACCW-1:0] acc_ff, acc_in;
   logic [BPW-1:0]  b_pad;
   logic [DIG-1:0]  digit;
   logic            last;

   assign b_pad = BPW'(op_b);
   assign digit = b_pad[ci_ff*DIG +: DIG];
   assign last  = (ci_ff == '0);

   always_comb begin
      busy_in = busy_ff;
      add_in  = add_ff;
      ci_in   = ci_ff;
      pp_in   = pp_ff;
      acc_in  = acc_ff;
      if (start) begin
         busy_in = 1'b1;
         add_in  = 1'b0;
         ci_in   = CI_W'(NDIG - 1);
         acc_in  = '0;
      end else if (busy_ff) begin
         if (!add_ff) begin
            pp_in  = {{DIG{1'b0}}, op_a} * {{VALUE_BITS{1'b0}}, digit};
            add_in = 1'b1;
         end else begin
            acc_in = (acc_ff << DIG) + ACCW'(pp_ff);
            add_in = 1'b0;
            if (last) begin
               busy_in = 1'b0;
            end else begin
               ci_in = ci_ff - CI_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         add_ff  <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         add_ff  <= add_in;
      end
      ci_ff  <= ci_in;
      pp_ff  <= pp_in;
      acc_ff <= acc_in;
   end

   assign product   = acc_ff;
   assign stat.busy = busy_ff;
   // product is complete at the edge that ends this cycle
   assign stat.done = busy_ff & add_ff & last;

   `INR_ASSERT_IMP(a_no_start_busy, clock, reset, start, !busy_ff)
   `INR_ASSERT_NXT(a_done_pulse, clock, reset, stat.done, !stat.done)
   `INR_ASSERT_IMP(a_add_when_busy, clock, reset, add_ff, busy_ff)

endmodule

`default_nettype wire

// ----- hw/rtl/integer_nth_root.sv -----
// Integer n-th root: for each request transaction (value, degree) returns the
// largest root with root^degree <= value, an exact flag, and bad_degree when the
// degree is zero. The root is found one bit a step from the top down; each
// candidate's power is built by a shared multiplier that takes one 16-bit digit
// of the candidate at a time. Each candidate needs at most degree multiplies,
// fewer when its power passes the value first; a zero degree goes straight to
// the result. One transaction is worked at a time; a finished response waits in
// an output register while the next request is accepted.
// Depends on inr_pkg, inr_req_if, inr_rsp_if, inr_mul_unit, assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module integer_nth_root #(
   parameter int VALUE_BITS = inr_pkg::VALUE_BITS_DEF
) (
   input wire logic  clock,
   input wire logic  reset,
   inr_req_if.sink   req_ch,
   inr_rsp_if.source rsp_ch
);

   localparam int DIG   = inr_pkg::MUL_DIGIT_BITS;
   localparam int NDIG  = (VALUE_BITS + DIG - 1) / DIG;
   localparam int ACCW  = VALUE_BITS + NDIG * DIG;
   localparam int BIT_W = $clog2(VALUE_BITS);
   localparam int DW    = inr_pkg::DEGREE_BITS;

   inr_pkg::state_type    state_ff, state_in;
   logic [VALUE_BITS-1:0] value_ff, value_in;
   logic [DW-1:0]         degree_ff, degree_in;
   logic [VALUE_BITS-1:0] root_ff, root_in;
   logic [BIT_W-1:0]      bit_ff, bit_in;
   logic [VALUE_BITS-1:0] pow_ff, pow_in;
   logic [DW-1:0]         k_ff, k_in;
   logic                  exact_ff, exact_in;
   logic                  bad_ff, bad_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [VALUE_BITS-1:0] rsp_root_ff, rsp_root_in;
   logic                  rsp_exact_ff, rsp_exact_in;
   logic                  rsp_bad_ff, rsp_bad_in;

   logic                  mul_start;
   logic [ACCW-1:0]       prod;
   inr_pkg::mul_stat_type mul_stat;

   logic [VALUE_BITS-1:0] cand;
   logic [DW-1:0]         k_next;
   logic                  over;
   logic                  pow_full;
   logic                  cand_done;
   logic                  out_free;
   logic                  req_take;

   assign cand      = root_ff | (VALUE_BITS'(1) << bit_ff);
   assign k_next    = k_ff + DW'(1);
   assign over      = (prod > ACCW'(value_ff));
   assign pow_full  = (k_next == degree_ff);
   assign cand_done = over | pow_full;
   assign out_free  = !rsp_valid_ff | rsp_ch.ready;
   assign req_take  = req_ch.valid & (state_ff == inr_pkg::ST_IDLE);

   inr_mul_unit #(
      .VALUE_BITS(VALUE_BITS)
   ) u_mul (
      .clock  (clock),
      .reset  (reset),
      .start  (mul_start),
      .op_a   (pow_ff),
      .op_b   (cand),
      .product(prod),
      .stat   (mul_stat)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         inr_pkg::ST_IDLE: begin
            if (req_ch.valid) begin
               state_in = (req_ch.degree == '0) ? inr_pkg::ST_RESULT : inr_pkg::ST_CAND;
            end
         end
         inr_pkg::ST_CAND:  state_in = inr_pkg::ST_POWER;
         inr_pkg::ST_POWER: state_in = inr_pkg::ST_WAIT;
         inr_pkg::ST_WAIT: begin
            if (mul_stat.done) begin
               state_in = inr_pkg::ST_CHECK;
            end
         end
         inr_pkg::ST_CHECK: begin
            if (!cand_done) begin
               state_in = inr_pkg::ST_POWER;
            end else if (bit_ff == '0) begin
               state_in = inr_pkg::ST_RESULT;
            end else begin
               state_in = inr_pkg::ST_CAND;
            end
         end
         inr_pkg::ST_RESULT: begin
            if (out_free) begin
               state_in = inr_pkg::ST_IDLE;
            end
         end
         default: state_in = inr_pkg::ST_IDLE;
      endcase
   end

   // handshake and multiplier control
   always_comb begin
      req_ch.ready = (state_ff == inr_pkg::ST_IDLE);
      mul_start    = (state_ff == inr_pkg::ST_POWER);
   end

   // datapath
   always_comb begin
      value_in  = value_ff;
      degree_in = degree_ff;
      root_in   = root_ff;
      bit_in    = bit_ff;
      pow_in    = pow_ff;
      k_in      = k_ff;
      exact_in  = exact_ff;
      bad_in    = bad_ff;
      if (req_take) begin
         value_in  = req_ch.value;
         degree_in = req_ch.degree;
         root_in   = '0;
         bit_in    = BIT_W'(VALUE_BITS - 1);
         bad_in    = (req_ch.degree == '0);
         // with no candidate taken the root stays zero, exact only for zero
         exact_in  = (req_ch.degree != '0) && (req_ch.value == '0);
      end
      if (state_ff == inr_pkg::ST_CAND) begin
         pow_in = VALUE_BITS'(1);
         k_in   = '0;
      end
      if (state_ff == inr_pkg::ST_CHECK) begin
         if (!over) begin
            pow_in = prod[VALUE_BITS-1:0];
            k_in   = k_next;
            if (pow_full) begin
               root_in  = cand;
               exact_in = (prod == ACCW'(value_ff));
            end
         end
         // advance to the next root bit once this candidate is settled
         if (cand_done && (bit_ff != '0)) begin
            bit_in = bit_ff - BIT_W'(1);
         end
      end
   end

   // response register
   always_comb begin
      rsp_root_in  = rsp_root_ff;
      rsp_exact_in = rsp_exact_ff;
      rsp_bad_in   = rsp_bad_ff;
      rsp_valid_in = rsp_valid_ff & !rsp_ch.ready;
      if ((state_ff == inr_pkg::ST_RESULT) && out_free) begin
         rsp_valid_in = 1'b1;
         rsp_root_in  = bad_ff ? '0 : root_ff;
         rsp_exact_in = exact_ff & !bad_ff;
         rsp_bad_in   = bad_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= inr_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      value_ff     <= value_in;
      degree_ff    <= degree_in;
      root_ff      <= root_in;
      bit_ff       <= bit_in;
      pow_ff       <= pow_in;
      k_ff         <= k_in;
      exact_ff     <= exact_in;
      bad_ff       <= bad_in;
      rsp_root_ff  <= rsp_root_in;
      rsp_exact_ff <= rsp_exact_in;
      rsp_bad_ff   <= rsp_bad_in;
   end

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.root       = rsp_root_ff;
   assign rsp_ch.exact      = rsp_exact_ff;
   assign rsp_ch.bad_degree = rsp_bad_ff;

   `INR_ASSERT_NXT(a_accept_leaves_idle, clock, reset, req_take, state_ff != inr_pkg::ST_IDLE)
   `INR_ASSERT_IMP(a_done_in_wait, clock, reset, mul_stat.done, state_ff == inr_pkg::ST_WAIT)
   `INR_ASSERT_IMP(a_busy_in_wait, clock, reset, mul_stat.busy, state_ff == inr_pkg::ST_WAIT)
   `INR_ASSERT_IMP(a_power_bounded, clock, reset,
                   (state_ff == inr_pkg::ST_POWER) && (k_ff != '0), pow_ff <= value_ff)

endmodule

`default_nettype wire

// ----- sim/integer_nth_root_test.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for integer_nth_root: directed and random transactions
// checked against a bit-true root predictor held in a small scoreboard class.
// Depends on inr_pkg, inr_req_if, inr_rsp_if and the integer_nth_root RTL.

module integer_nth_root_test;

   localparam int VB               = inr_pkg::VALUE_BITS_DEF;
   localparam int DB               = inr_pkg::DEGREE_BITS;
   localparam int RANDOM_PER_PHASE = 140;
   localparam int HOLDOFF_CYCLES   = 4000;
   localparam int QUIET_LIMIT      = 40000;
   localparam int TAIL_CYCLES      = 6000;
   localparam logic [VB-1:0] VALUE_MAX = '1;

   typedef enum logic [1:0] {PWR_ABOVE, PWR_BELOW, PWR_EQUAL} power_order_type;

   typedef struct packed {
      logic [VB-1:0] root;
      logic          exact;
      logic          bad_degree;
   } root_result_type;

   class root_scoreboard;
      root_result_type awaited[$];
      int              failures;

      function new();
         failures = 0;
      endfunction

      // Build base^n step by step; give up as soon as it would pass the limit.
      static function power_order_type compare_power(longint unsigned base, int n,
                                                     longint unsigned limit);
         longint unsigned acc;
         acc = 1;
         for (int k = 0; k < n; k++) begin
            if (base != 0 && acc > limit / base) return PWR_ABOVE;
            acc = acc * base;
         end
         if (acc == limit) return PWR_EQUAL;
         return PWR_BELOW;
      endfunction

      static function root_result_type predict_root(logic [VB-1:0] v, logic [DB-1:0] d);
         root_result_type res;
         logic [VB-1:0]   r;
         logic [VB-1:0]   cand;
         res = '0;
         if (d == 0) begin
            res.bad_degree = 1'b1;
            return res;
         end
         r = '0;
         // settle one root bit at a time, top down
         for (int b = VB - 1; b >= 0; b--) begin
            cand    = r;
            cand[b] = 1'b1;
            if (compare_power(64'(cand), int'(d), 64'(v)) != PWR_ABOVE) r = cand;
         end
         res.root  = r;
         res.exact = (compare_power(64'(r), int'(d), 64'(v)) == PWR_EQUAL);
         return res;
      endfunction

      function void note_request(logic [VB-1:0] v, logic [DB-1:0] d);
         awaited.push_back(predict_root(v, d));
      endfunction

      function void check_response(logic [VB-1:0] root, logic exact, logic bad_degree);
         root_result_type want;
         if (awaited.size() == 0) begin
            $display("%0t: response with none outstanding: root %0d exact %0d bad_degree %0d",
                     $time, root, exact, bad_degree);
            failures++;
            return;
         end
         want = awaited.pop_front();
         if (root !== want.root) begin
            $display("%0t: root mismatch, expected %0d, actual %0d", $time, want.root, root);
            failures++;
         end
         if (exact !== want.exact) begin
            $display("%0t: exact mismatch, expected %0d, actual %0d", $time, want.exact, exact);
            failures++;
         end
         if (bad_degree !== want.bad_degree) begin
            $display("%0t: bad_degree mismatch, expected %0d, actual %0d",
                     $time, want.bad_degree, bad_degree);
            failures++;
         end
      endfunction

      function int pending();
         return awaited.size();
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;
   int   send_idle_pct   = 0;
   int   recv_stall_pct  = 0;
   int   holdoff_request = 0;
   int   quiet_cycles    = 0;

   root_scoreboard sb = new();

   inr_req_if #(.VALUE_BITS(VB)) req_bus ();
   inr_rsp_if #(.VALUE_BITS(VB)) rsp_bus ();

   integer_nth_root #(.VALUE_BITS(VB)) uut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_bus.sink),
      .rsp_ch (rsp_bus.source)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Offer one transaction, hold it until taken, then maybe go idle a while.
   task automatic offer_root_request(input logic [VB-1:0] v, input logic [DB-1:0] d);
      req_bus.value  <= v;
      req_bus.degree <= d;
      req_bus.valid  <= 1'b1;
      do @(posedge clock); while (!req_bus.ready);
      sb.note_request(v, d);
      if ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
   endtask

   // Response side: check what is taken, stall at random or for a long hold-off.
   initial begin : response_side
      int holdoff;
      holdoff = 0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_bus.valid && rsp_bus.ready)
            sb.check_response(rsp_bus.root, rsp_bus.exact, rsp_bus.bad_degree);
         if (holdoff_request != 0) begin
            holdoff         = holdoff_request;
            holdoff_request = 0;
         end
         if (holdoff > 0) begin
            holdoff--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("%0t: no transaction for %0d cycles", $time, QUIET_LIMIT);
         $display("integer_nth_root verification failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin : stimulus
      logic [VB-1:0]   val;
      logic [DB-1:0]   deg;
      root_result_type top_root;
      longint unsigned base;
      longint unsigned pw;
      int              pick;

      reset          <= 1'b1;
      req_bus.valid  <= 1'b0;
      req_bus.value  <= '0;
      req_bus.degree <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // zero degree, zero value, degree one, field extremes, exact powers and neighbours
      offer_root_request('0, '0);
      offer_root_request(VALUE_MAX, '0);
      offer_root_request('0, 5'd5);
      offer_root_request('0, 5'd1);
      offer_root_request('0, 5'd31);
      offer_root_request(VALUE_MAX, 5'd1);
      offer_root_request(31'd12345, 5'd1);
      offer_root_request(VALUE_MAX, 5'd2);
      offer_root_request(31'd2147395600, 5'd2);
      offer_root_request(31'd2147395599, 5'd2);
      offer_root_request(31'd1, 5'd2);
      offer_root_request(31'd2, 5'd2);
      offer_root_request(31'd3, 5'd2);
      offer_root_request(31'd4, 5'd2);
      offer_root_request(31'd2146689000, 5'd3);
      offer_root_request(31'd2146688999, 5'd3);
      offer_root_request(VALUE_MAX, 5'd16);
      offer_root_request(31'd43046721, 5'd16);
      offer_root_request(31'h40000000, 5'd30);
      offer_root_request(31'h3FFFFFFF, 5'd30);
      offer_root_request(VALUE_MAX, 5'd31);
      offer_root_request(31'd1, 5'd31);

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 86; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 86; end
            default: begin send_idle_pct = 12; recv_stall_pct = 12; end
         endcase
         for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
            // hold the response side off while requests keep coming
            if (phase == 0 && n == 40) holdoff_request = HOLDOFF_CYCLES;
            pick = $urandom_range(0, 9);
            deg  = DB'($urandom_range(1, 31));
            val  = VB'($urandom);
            val  = val >> $urandom_range(0, 30);
            if (pick == 0) begin
               deg = '0;
            end else if (pick <= 2) begin
               val = VB'($urandom);
            end else if (pick <= 4) begin
               deg = DB'($urandom_range(1, 4));
            end else if (pick <= 7) begin
               // exact power, or one either side of it
               if ($urandom_range(0, 1)) deg = DB'($urandom_range(2, 6));
               top_root = sb.predict_root(VALUE_MAX, deg);
               base     = 64'($urandom_range(0, top_root.root));
               pw       = 1;
               repeat (deg) pw = pw * base;
               case ($urandom_range(0, 3))
                  0: if (pw != 0) pw = pw - 1;
                  1: if (pw != VALUE_MAX) pw = pw + 1;
                  default: ;
               endcase
               val = pw[VB-1:0];
            end
            offer_root_request(val, deg);
         end
      end
      req_bus.valid <= 1'b0;

      while (sb.pending() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (sb.failures == 0)
         $display("integer_nth_root verification clean");
      else
         $display("integer_nth_root verification failed");
      $finish;
   end

endmodule
